// ===== design/scv_pkg.sv =====
// ----------------------------------------------------------------------------
// scv_pkg
// Shared types and constants for the serial command checksum validator.
// ----------------------------------------------------------------------------
package scv_pkg;

  // token limit per message
  localparam logic [4:0] MaxTokens = 5'd10;

  // reset value of the start character register
  localparam logic [7:0] StartCharReset = 8'h24;

  // result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_RESPONSE   = 3'd1;
  localparam logic [2:0] ST_INVALID    = 3'd2;
  localparam logic [2:0] ST_UNKNOWN    = 3'd3;
  localparam logic [2:0] ST_SENT       = 3'd4;
  localparam logic [2:0] ST_SUPPRESSED = 3'd5;

  // command kinds
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_BOOT   = 2'd1;
  localparam logic [1:0] KIND_STATE  = 2'd2;
  localparam logic [1:0] KIND_BUTTON = 2'd3;

  // byte positions within a message
  localparam logic [1:0] POS_START  = 2'd0;
  localparam logic [1:0] POS_CMD0   = 2'd1;
  localparam logic [1:0] POS_CMD1   = 2'd2;
  localparam logic [1:0] POS_LATER  = 2'd3;

  // checksum kinds
  localparam logic [1:0] CK_NONE = 2'd0;
  localparam logic [1:0] CK_ADD  = 2'd1;
  localparam logic [1:0] CK_XOR  = 2'd2;

  // hex digit count value meaning scan stopped
  localparam logic [1:0] HEX_STOP = 2'd3;

  // input opcodes
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // characters
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // one result word
  typedef struct packed {
    logic       pending_now;
    logic [4:0] token_total;
    logic [1:0] command_kind;
    logic [2:0] status;
  } scv_result_t;

endpackage

// ===== design/scv_core.sv =====
// ----------------------------------------------------------------------------
// scv_core
// Message state registers and the single-pass byte parser that updates them
// and forms a result on a last byte or a request.
// ----------------------------------------------------------------------------
module scv_core import scv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        opcode_i,
  input  logic [7:0]  msg_byte_i,
  input  logic        msg_last_i,
  input  logic [7:0]  start_char_i,
  output logic        res_valid_o,
  output scv_result_t res_o
);

  logic [1:0]  pos_q, pos_d;
  logic [7:0]  add_q, add_d;
  logic [7:0]  xr_q, xr_d;
  logic [4:0]  tok_q, tok_d;
  logic [1:0]  ck_q, ck_d;
  logic [1:0]  hds_q, hds_d;
  logic [7:0]  rcv_q, rcv_d;
  logic [15:0] cmd_q, cmd_d;
  logic [1:0]  err_q, err_d;
  logic        pend_q, pend_d;

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic        msg_ok;

  // hex digit decode
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (msg_byte_i >= 8'h30 && msg_byte_i <= 8'h39) begin
      hex_val = 4'(msg_byte_i - 8'h30);
    end else if (msg_byte_i >= 8'h41 && msg_byte_i <= 8'h46) begin
      hex_val = 4'(msg_byte_i - 8'h37);
    end else if (msg_byte_i >= 8'h61 && msg_byte_i <= 8'h66) begin
      hex_val = 4'(msg_byte_i - 8'h57);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // byte parse, validity check and result
  always_comb begin
    pos_d  = pos_q;
    add_d  = add_q;
    xr_d   = xr_q;
    tok_d  = tok_q;
    ck_d   = ck_q;
    hds_d  = hds_q;
    rcv_d  = rcv_q;
    cmd_d  = cmd_q;
    err_d  = err_q;
    pend_d = pend_q;
    msg_ok = 1'b0;
    res_valid_o = 1'b0;
    res_o = '{pending_now: 1'b0, token_total: 5'd0, command_kind: KIND_NONE,
              status: ST_INVALID};

    if (accept_i) begin
      if (opcode_i == OP_REQUEST) begin
        res_valid_o = 1'b1;
        if (pend_q) begin
          res_o.status = ST_SUPPRESSED;
        end else begin
          pend_d = 1'b1;
          res_o.status = ST_SENT;
        end
      end else begin
        // message byte
        case (pos_q)
          POS_START: begin
            add_d = start_char_i;
            xr_d  = start_char_i;
            pos_d = POS_CMD0;
          end
          POS_CMD0: begin
            add_d = add_q + msg_byte_i;
            xr_d  = xr_q ^ msg_byte_i;
            tok_d = 5'd1;
            cmd_d = {msg_byte_i, 8'h00};
            pos_d = POS_CMD1;
            if (msg_byte_i == 8'h00) hds_d = HEX_STOP;
          end
          default: begin
            if (hds_q != HEX_STOP) begin
              if (ck_q != CK_NONE) begin
                if (hds_q < 2'd2) begin
                  if (!hex_ok) begin
                    err_d[1] = 1'b1;
                    hds_d    = HEX_STOP;
                  end else begin
                    rcv_d = {rcv_q[3:0], hex_val};
                    hds_d = hds_q + 2'd1;
                  end
                end
              end else begin
                if (msg_byte_i == 8'h00) begin
                  hds_d = HEX_STOP;
                end else if (msg_byte_i == CH_SPACE) begin
                  if (tok_q >= MaxTokens) begin
                    err_d[0] = 1'b1;
                    hds_d    = HEX_STOP;
                  end else begin
                    add_d = add_q + msg_byte_i;
                    xr_d  = xr_q ^ msg_byte_i;
                    tok_d = tok_q + 5'd1;
                  end
                end else if (msg_byte_i == CH_STAR || msg_byte_i == CH_CARET) begin
                  ck_d  = (msg_byte_i == CH_STAR) ? CK_ADD : CK_XOR;
                  hds_d = 2'd0;
                  rcv_d = 8'h00;
                end else begin
                  add_d = add_q + msg_byte_i;
                  xr_d  = xr_q ^ msg_byte_i;
                  if (pos_q == POS_CMD1) cmd_d = {cmd_q[15:8], msg_byte_i};
                end
                pos_d = POS_LATER;
              end
            end
          end
        endcase

        // end of message: classify, then clear the message state
        if (msg_last_i) begin
          res_valid_o = 1'b1;
          if (err_d[0]) begin
            msg_ok = 1'b0;
          end else if (ck_d == CK_NONE) begin
            msg_ok = 1'b1;
          end else if (err_d[1] || hds_d != 2'd2) begin
            msg_ok = 1'b0;
          end else if (ck_d == CK_ADD) begin
            msg_ok = (rcv_d == add_d);
          end else begin
            msg_ok = (rcv_d == xr_d);
          end

          if (pos_q != POS_START && msg_ok) begin
            res_o.token_total = tok_d;
            res_o.status      = ST_UNKNOWN;
            if (cmd_d[15:8] == CH_A) begin
              if (cmd_d[7:0] == CH_B) begin
                res_o.status = ST_OK;
                res_o.command_kind = KIND_BOOT;
              end else if (cmd_d[7:0] == CH_T) begin
                res_o.status = ST_OK;
                res_o.command_kind = KIND_STATE;
              end else if (cmd_d[7:0] == CH_N) begin
                res_o.status = ST_OK;
                res_o.command_kind = KIND_BUTTON;
              end
            end else if (cmd_d[15:8] == CH_O || cmd_d[15:8] == CH_N) begin
              pend_d = 1'b0;
              res_o.status = ST_RESPONSE;
            end
          end

          pos_d = POS_START;
          add_d = 8'h00;
          xr_d  = 8'h00;
          tok_d = 5'd0;
          ck_d  = CK_NONE;
          hds_d = 2'd0;
          rcv_d = 8'h00;
          cmd_d = 16'h0000;
          err_d = 2'b00;
        end
      end
      res_o.pending_now = pend_d;
    end
  end

  // message state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_START;
      add_q  <= 8'h00;
      xr_q   <= 8'h00;
      tok_q  <= 5'd0;
      ck_q   <= CK_NONE;
      hds_q  <= 2'd0;
      rcv_q  <= 8'h00;
      cmd_q  <= 16'h0000;
      err_q  <= 2'b00;
      pend_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      add_q  <= add_d;
      xr_q   <= xr_d;
      tok_q  <= tok_d;
      ck_q   <= ck_d;
      hds_q  <= hds_d;
      rcv_q  <= rcv_d;
      cmd_q  <= cmd_d;
      err_q  <= err_d;
      pend_q <= pend_d;
    end
  end

endmodule

// ===== design/scv_out_reg.sv =====
// ----------------------------------------------------------------------------
// scv_out_reg
// Result register on the output stream; frees up as soon as the word leaves.
// ----------------------------------------------------------------------------
module scv_out_reg import scv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  scv_result_t res_i,
  output logic        space_o,
  output logic        valid_o,
  input  logic        ready_i,
  output scv_result_t res_o
);

  logic        valid_q, valid_d;
  scv_result_t res_q;

  // room for a new word when empty or when the held word leaves now
  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_i) valid_d = 1'b0;
    if (load_i)  valid_d = 1'b1;
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== design/serial_command_checksum_validator_top.sv =====
// ----------------------------------------------------------------------------
// serial_command_checksum_validator_top
// Checks text command messages byte by byte against an additive or XOR
// checksum and sorts each finished message; also tracks request pending.
//
// Input stream: one byte per word. tuser = 0 marks a message byte,
// tuser = 1 a request send attempt; tlast marks the final message byte.
// Output stream: one word per last byte and per request, none otherwise.
// Config channel: cfg_data_i writes the start character that seeds both
// checksums; write only while the block is idle.
// Latency: a result appears on the output in the cycle after the item that
// causes it is taken. Throughput: one item per cycle when not stalled,
// set by the single parse step between state and result registers.
// A stalled receiver holds the result register; input stays open while the
// held word leaves in the same cycle, otherwise tready drops.
// Reset clears all message state, the pending flag and the output valid, and
// sets the start character to '$'.
// ----------------------------------------------------------------------------
module serial_command_checksum_validator_top import scv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,     // start_char
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i, // [7:0] msg_byte
  input  logic        s_axis_tuser_i, // [0] opcode
  input  logic        s_axis_tlast_i,
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o  // [2:0] status, [4:3] command_kind,
                                      // [9:5] token_total, [10] pending_now
);

  logic [7:0]  start_char_q;
  logic        in_accept;
  logic        res_valid;
  scv_result_t res_core;
  scv_result_t res_out;
  logic        space;

  // start character register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_char_q <= StartCharReset;
    end else if (cfg_valid_i) begin
      start_char_q <= cfg_data_i;
    end
  end

  // input handshake
  assign s_axis_tready_o = space;
  assign in_accept       = s_axis_tvalid_i && space;

  scv_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .opcode_i     (s_axis_tuser_i),
    .msg_byte_i   (s_axis_tdata_i),
    .msg_last_i   (s_axis_tlast_i),
    .start_char_i (start_char_q),
    .res_valid_o  (res_valid),
    .res_o        (res_core)
  );

  scv_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res_core),
    .space_o (space),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (res_out)
  );

  // output packing
  assign m_axis_tdata_o = {5'd0, res_out};

  // a request always yields a result word next cycle
  a_req_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && s_axis_tuser_i == OP_REQUEST) |=> m_axis_tvalid_o)
    else $error("request produced no result");

  // a last message byte always yields a result word next cycle
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && s_axis_tuser_i == OP_BYTE && s_axis_tlast_i) |=> m_axis_tvalid_o)
    else $error("last byte produced no result");

  // command kind is set exactly for an ok command
  a_kind_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      ((res_out.status == ST_OK) == (res_out.command_kind != KIND_NONE)))
    else $error("command kind does not match status");

  // no token count on invalid or request results
  a_tok_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (res_out.status == ST_INVALID ||
      res_out.status == ST_SENT || res_out.status == ST_SUPPRESSED))
      |-> (res_out.token_total == 5'd0))
    else $error("token count on a failed or request result");

endmodule
